FILE: hdl/pqls_pkg.sv
`timescale 1ns / 1ps

package pqls_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int DATA_W          = 32;
  localparam int PRIO_W          = 16;
  localparam int STATUS_W        = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_OVERFLOW  = 2'd1;
  localparam status_t STATUS_UNDERFLOW = 2'd2;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  // Value returned by a dequeue from an empty queue.
  localparam logic signed [DATA_W-1:0] DATA_EMPTY = -32'sd1;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic signed [DATA_W-1:0] data;
  } entry_t;

endpackage

FILE: hdl/priority_queue_linear_scan_unit.sv
`timescale 1ns / 1ps

// Priority queue of QUEUE_DEPTH (value, priority) entries held unsorted in one
// synchronous memory. Every transaction returns exactly one result. An enqueue
// goes from ST_IDLE to ST_EMIT, which loads its result into the output register
// once that register is free, and the unit then returns to ST_IDLE to accept the
// next transaction. A dequeue of a queue holding N entries reads every entry once
// to find the highest priority (the earliest entry wins a tie), then moves each
// later entry down one place, so its result passes through ST_SCAN, ST_SHIFT and
// ST_EMIT before it reaches the output register; no new transaction is accepted
// until it has left ST_EMIT. The single read port of the entry memory serves
// both the search and the compaction one entry a cycle. A new transaction is
// taken while a finished result still waits at the output; a later result that
// finds the output register occupied waits until the earlier one is taken.
module priority_queue_linear_scan_unit #(
  parameter int QUEUE_DEPTH = pqls_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_action,
  input  logic signed [pqls_pkg::DATA_W-1:0]     in_data_in,
  input  logic signed [pqls_pkg::PRIO_W-1:0]     in_priority_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [pqls_pkg::DATA_W-1:0]     out_data_out,
  output pqls_pkg::status_t                      out_status
);

  import pqls_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         ptr_r, ptr_nxt;
  logic                     lag_vld_r, lag_vld_nxt;
  logic [IDX_W-1:0]         lag_idx_r, lag_idx_nxt;
  logic [IDX_W-1:0]         best_idx_r, best_idx_nxt;
  logic signed [PRIO_W-1:0] best_prio_r, best_prio_nxt;
  logic signed [DATA_W-1:0] best_data_r, best_data_nxt;
  logic signed [DATA_W-1:0] res_data_r, res_data_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  status_t                  out_status_r, out_status_nxt;

  entry_t                   mem [QUEUE_DEPTH];
  entry_t                   rd_q_r;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  entry_t                   wr_data;

  logic                     take_cur;
  logic [IDX_W-1:0]         best_idx_c;
  logic signed [DATA_W-1:0] best_data_c;
  logic                     last_lag;

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_status   = out_status_r;

  // The entry arriving from memory wins if it is the first one or strictly larger,
  // which keeps the earliest entry on a tie.
  assign take_cur    = (lag_idx_r == '0) || ($signed(rd_q_r.prio) > best_prio_r);
  assign best_idx_c  = take_cur ? lag_idx_r : best_idx_r;
  assign best_data_c = take_cur ? rd_q_r.data : best_data_r;
  assign last_lag    = lag_vld_r && (CNT_W'(lag_idx_r) == cnt_r - 1'b1);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    lag_vld_nxt    = 1'b0;
    lag_idx_nxt    = lag_idx_r;
    best_idx_nxt   = best_idx_r;
    best_prio_nxt  = best_prio_r;
    best_data_nxt  = best_data_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    rd_addr        = ptr_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = cnt_r[IDX_W-1:0];
    wr_data        = '{prio: in_priority_in, data: in_data_in};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_ENQUEUE) begin
            res_data_nxt = '0;
            if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
              res_status_nxt = STATUS_OVERFLOW;
            end else begin
              res_status_nxt = STATUS_OK;
              wr_en          = 1'b1;
              cnt_nxt        = cnt_r + 1'b1;
            end
            state_nxt = ST_EMIT;
          end else if (cnt_r == '0) begin
            res_data_nxt   = DATA_EMPTY;
            res_status_nxt = STATUS_UNDERFLOW;
            state_nxt      = ST_EMIT;
          end else begin
            ptr_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (ptr_r < cnt_r) begin
          rd_en       = 1'b1;
          lag_vld_nxt = 1'b1;
          lag_idx_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt     = ptr_r + 1'b1;
        end
        if (lag_vld_r) begin
          best_idx_nxt  = best_idx_c;
          best_prio_nxt = take_cur ? $signed(rd_q_r.prio) : best_prio_r;
          best_data_nxt = best_data_c;
        end
        if (last_lag) begin
          res_data_nxt   = best_data_c;
          res_status_nxt = STATUS_OK;
          ptr_nxt        = CNT_W'(best_idx_c) + 1'b1;
          lag_vld_nxt    = 1'b0;
          state_nxt      = ST_SHIFT;
        end
      end

      ST_SHIFT: begin
        // Read entry ptr while the entry read last cycle lands one place lower.
        if (lag_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = lag_idx_r - 1'b1;
          wr_data = rd_q_r;
        end
        if (ptr_r < cnt_r) begin
          rd_en       = 1'b1;
          lag_vld_nxt = 1'b1;
          lag_idx_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt     = ptr_r + 1'b1;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      lag_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lag_vld_r   <= lag_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    lag_idx_r    <= lag_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_prio_r  <= best_prio_nxt;
    best_data_r  <= best_data_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_busy_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_SHIFT) |-> cnt_r != '0)
    else $error("search or compaction running on an empty queue");

  a_shift_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && wr_en) |-> (lag_idx_r != '0 && CNT_W'(lag_idx_r) < cnt_r))
    else $error("compaction writes outside the stored entries");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished result not passed to the output register");

  a_shift_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && state_nxt == ST_EMIT) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("dequeue did not shrink the entry count");

endmodule
